// ----- rtl/core/mm64_pkg.sv -----
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared constants and types for the streaming 64-bit Murmur hash block.
// ----------------------------------------------------------------------------
package mm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned NB_W   = 4;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_MUL,
    ST_DISPATCH,
    ST_K_MUL1,
    ST_K_MUL2,
    ST_H_MUL,
    ST_FIN_MUL,
    ST_EMIT
  } mm64_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] operand;
  } mm64_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } mm64_mul_rsp_t;

  function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
    xorshift = v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// ----- rtl/core/mm64_mul.sv -----
// ----------------------------------------------------------------------------
// mm64_mul
// Multiplies a 64-bit operand by the mixing constant modulo 2^64, using one
// 32x32 multiplier for the low and both cross partial products in turn.
// ----------------------------------------------------------------------------
module mm64_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mm64_pkg::mm64_mul_req_t req,
  output mm64_pkg::mm64_mul_rsp_t rsp
);
  import mm64_pkg::*;

  logic [WORD_W-1:0] op_r, op_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       a_sel, b_sel;
  logic [63:0]       prod;

  always_comb begin
    a_sel = (ph_r == 2'd2) ? op_r[63:32] : op_r[31:0];
    b_sel = (ph_r == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    prod  = {32'h0, a_sel} * {32'h0, b_sel};

    op_nxt   = op_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (req.start) begin
      op_nxt   = req.operand;
      ph_nxt   = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ph_r == 2'd0) begin
        acc_nxt = prod;
      end else begin
        acc_nxt = acc_r + {prod[31:0], 32'h0};
      end
      if (ph_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        ph_nxt   = 2'd0;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

// ----- rtl/core/murmur64a_hash_stream.sv -----
// ----------------------------------------------------------------------------
// murmur64a_hash_stream
// Computes the 64-bit MurmurHash64A of a message streamed as 64-bit words.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// in_*      slave      one message word, tlast marks the final word
// out_*     master     one finished hash per message
// cfg_*     write      seed register
//
// Each word uses one to five constant multiplications on the shared 32x32
// multiplier plus control steps. The block is ready only when idle, so it
// takes no new word before it is through with the last one.
// A finished hash waits in the output register; the sequencer holds in its
// emit step until that register is free. Reset clears the seed to zero and
// marks the next word as a message start.
// ----------------------------------------------------------------------------
module murmur64a_hash_stream (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: data_word[63:0], valid_bytes[67:64], message_length[98:68].
  input  logic [mm64_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: hash_value[63:0].
  output logic [mm64_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [mm64_pkg::SEED_W-1:0]          cfg_wdata
);
  import mm64_pkg::*;

  mm64_state_t       state_r, state_nxt;
  logic [SEED_W-1:0] seed_r;
  logic [WORD_W-1:0] h_r, h_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [NB_W-1:0]   nb_r, nb_nxt;
  logic              last_r, last_nxt;
  logic              msg_start_r, msg_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  mm64_mul_req_t     mul_req;
  mm64_mul_rsp_t     mul_rsp;

  logic [WORD_W-1:0] in_word;
  logic [NB_W-1:0]   in_nb;
  logic [LEN_W-1:0]  in_len;
  logic [NB_W-1:0]   nb_eff;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] fin_val;

  assign in_word = in_tdata[63:0];
  assign in_nb   = in_tdata[67:64];
  assign in_len  = in_tdata[98:68];

  mm64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    if (!in_tlast || in_nb > 4'd8) begin
      nb_eff = 4'd8;
    end else begin
      nb_eff = in_nb;
    end
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < nb_r) ? word_r[i*8 +: 8] : 8'h00;
    end
    fin_val = xorshift(mul_rsp.result);
  end

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    word_nxt      = word_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    msg_start_nxt = msg_start_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_req.start   = 1'b0;
    mul_req.operand = x_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          word_nxt = in_word;
          nb_nxt   = nb_eff;
          last_nxt = in_tlast;
          if (msg_start_r) begin
            mul_req.start   = 1'b1;
            mul_req.operand = {{(WORD_W-LEN_W){1'b0}}, in_len};
            state_nxt       = ST_LEN_MUL;
          end else begin
            state_nxt = ST_DISPATCH;
          end
        end
      end
      ST_LEN_MUL: begin
        if (mul_rsp.done) begin
          h_nxt     = {{(WORD_W-SEED_W){1'b0}}, seed_r} ^ mul_rsp.result;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        mul_req.start = 1'b1;
        if (nb_r == 4'd8) begin
          mul_req.operand = word_r;
          state_nxt       = ST_K_MUL1;
        end else if (nb_r != 4'd0) begin
          mul_req.operand = h_r ^ masked;
          state_nxt       = ST_H_MUL;
        end else begin
          mul_req.operand = xorshift(h_r);
          state_nxt       = ST_FIN_MUL;
        end
      end
      ST_K_MUL1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = fin_val;
          state_nxt       = ST_K_MUL2;
        end
      end
      ST_K_MUL2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_r ^ mul_rsp.result;
          state_nxt       = ST_H_MUL;
        end
      end
      ST_H_MUL: begin
        if (mul_rsp.done) begin
          h_nxt = mul_rsp.result;
          if (last_r) begin
            mul_req.start   = 1'b1;
            mul_req.operand = fin_val;
            state_nxt       = ST_FIN_MUL;
          end else begin
            msg_start_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_FIN_MUL: begin
        if (mul_rsp.done) begin
          x_nxt     = fin_val;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = x_r;
          h_nxt         = x_r;
          msg_start_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      h_r         <= '0;
      msg_start_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      msg_start_r <= msg_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
    x_r        <= x_nxt;
    word_r     <= word_nxt;
    nb_r       <= nb_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- verif/tb_murmur64a_hash_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur64a_hash_stream
// Streams messages through the hash block and checks every finished hash.
// The stimulus covers directed corner words, then random messages under
// several idle and stall patterns and seed values. Each accepted input word
// is fed to a behavioral hash model, and every output transaction is
// compared in order against the hashes that the model has produced.
// ----------------------------------------------------------------------------
module tb_murmur64a_hash_stream;
  import mm64_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic [NB_W-1:0]   nbytes;
    logic              last;
    logic [LEN_W-1:0]  msg_len;
  } msg_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [SEED_W-1:0]      cfg_wdata = '0;

  msg_word_t         word_queue[$];
  logic [63:0]       expected_hashes[$];
  logic [SEED_W-1:0] hash_seed = '0;
  logic [63:0]       partial_hash = '0;
  logic              word_at_start = 1'b1;
  bit                in_taken = 1'b0;
  bit                hold_off = 1'b0;
  bit                choke_req = 1'b0;
  int unsigned       src_idle_pct = 0;
  int unsigned       snk_stall_pct = 0;
  int unsigned       fail_count = 0;

  murmur64a_hash_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] scramble_word(input logic [63:0] k);
    logic [63:0] t;
    t = k * MIX_MUL;
    t = t ^ (t >> MIX_SHIFT);
    t = t * MIX_MUL;
    return t;
  endfunction

  task automatic absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic last, input logic [30:0] msg_len);
    logic [63:0] h;
    logic [63:0] mask;
    int unsigned n;
    n = nbytes;
    if (n > 8) n = 8;
    if (!last) n = 8;
    h = word_at_start ? ({32'b0, hash_seed} ^ ({33'b0, msg_len} * MIX_MUL))
                      : partial_hash;
    if (n == 8) begin
      h = (h ^ scramble_word(data)) * MIX_MUL;
    end else if (n != 0) begin
      mask = (64'd1 << (8 * n)) - 64'd1;
      h = (h ^ (data & mask)) * MIX_MUL;
    end
    if (last) begin
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL;
      h = h ^ (h >> MIX_SHIFT);
      expected_hashes.push_back(h);
    end
    partial_hash = h;
    word_at_start = last;
  endtask

  always @(negedge clk) begin : drive_words
    msg_word_t w;
    if (!in_tvalid || in_taken) begin
      if (word_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        w = word_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {5'b0, w.msg_len, w.nbytes, w.data};
        in_tlast  <= w.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : watch_bus
    logic [63:0] want;
    in_taken = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_taken) begin
        absorb_word(in_tdata[63:0], in_tdata[67:64], in_tlast, in_tdata[98:68]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected hash transaction, expected none, actual %h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: hash mismatch, expected %h, actual %h",
                     $time, want, out_tdata);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : back_pressure
    wait (choke_req);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void push_word(input logic [63:0] data, input logic [3:0] nbytes,
                                    input logic last, input logic [30:0] msg_len);
    msg_word_t w;
    w.data    = data;
    w.nbytes  = nbytes;
    w.last    = last;
    w.msg_len = msg_len;
    word_queue.push_back(w);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // Queues one message of the given byte count and returns its word count.
  function automatic int queue_message(input int unsigned nbytes, input bit messy);
    int unsigned full_words;
    int unsigned tail;
    int unsigned count;
    bit          full_last;
    logic [30:0] len_field;
    logic [3:0]  nb;
    full_words = nbytes / 8;
    tail       = nbytes % 8;
    full_last  = (tail == 0) && (full_words > 0) && $urandom_range(1);
    len_field  = messy && $urandom_range(1) ? 31'($urandom()) : 31'(nbytes);
    count      = full_last ? full_words : full_words + 1;
    for (int unsigned i = 0; i < count; i++) begin
      if (i + 1 == count) begin
        nb = full_last ? (messy ? 4'($urandom_range(15, 8)) : 4'd8) : 4'(tail);
        push_word(rand_word(), nb, 1'b1, len_field);
      end else begin
        nb = messy ? 4'($urandom_range(15)) : 4'd8;
        push_word(rand_word(), nb, 1'b0, messy ? 31'($urandom()) : len_field);
      end
    end
    return count;
  endfunction

  task automatic queue_random_messages(input int target);
    int          added;
    int unsigned pick;
    int unsigned nbytes;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(99);
      if (pick < 70) nbytes = $urandom_range(24);
      else if (pick < 95) nbytes = $urandom_range(80, 25);
      else nbytes = $urandom_range(200, 81);
      added += queue_message(nbytes, $urandom_range(99) < 15);
    end
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    hash_seed = value;
  endtask

  task automatic drain();
    while (word_queue.size() > 0 || in_tvalid || expected_hashes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin : main_sequence
    int unsigned       idle_pcts[4];
    int unsigned       stall_pcts[4];
    logic [SEED_W-1:0] seeds[4];
    idle_pcts  = '{0, 60, 0, 22};
    stall_pcts = '{0, 0, 60, 22};
    seeds      = '{32'hffff_ffff, 32'($urandom()), 32'h8000_0001, 32'($urandom())};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner words: empty, full and partial last words, oversize
    // byte counts, short non-last words and a length field that disagrees.
    write_seed('0);
    push_word(rand_word(), 4'd0, 1'b1, 31'd0);
    push_word('0, 4'd8, 1'b1, 31'd8);
    push_word('1, 4'd15, 1'b1, 31'h7fff_ffff);
    for (int n = 1; n < 8; n++) push_word(rand_word(), 4'(n), 1'b1, 31'(n));
    push_word(rand_word(), 4'd9, 1'b1, 31'd8);
    push_word('1, 4'd3, 1'b0, 31'd8);
    push_word(rand_word(), 4'd0, 1'b1, 31'd8);
    push_word(rand_word(), 4'd8, 1'b0, 31'd21);
    push_word(rand_word(), 4'd8, 1'b0, 31'd0);
    push_word(rand_word(), 4'd5, 1'b1, 31'd0);
    push_word(rand_word(), 4'd4, 1'b1, 31'd1234567);
    push_word(rand_word(), 4'd12, 1'b0, 31'd16);
    push_word(rand_word(), 4'd8, 1'b1, 31'd16);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_seed(seeds[p]);
      src_idle_pct  = idle_pcts[p];
      snk_stall_pct = stall_pcts[p];
      if (p == 0) choke_req = 1'b1;
      queue_random_messages(165);
      drain();
    end

    if (expected_hashes.size() > 0) begin
      $display("%0t: %0d expected hashes never arrived", $time, expected_hashes.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
